// ----- rtl/mhpq_pkg.sv -----
// Shared types and constants for the min-heap priority queue core.
`default_nettype none

package mhpq_pkg;

  // Fixed field widths
  localparam int KEY_W     = 32;
  localparam int CNT_OUT_W = 9;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Read address selects
  localparam logic [2:0] RD_LAST   = 3'd0;
  localparam logic [2:0] RD_PARENT = 3'd1;
  localparam logic [2:0] RD_LEFT   = 3'd2;
  localparam logic [2:0] RD_RIGHT  = 3'd3;
  localparam logic [2:0] RD_ROOT   = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       set_err;
    logic       count_inc;
    logic       count_dec;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       key_from_rd;
    logic       latch_left;
    logic       up_step;
    logic       dn_step;
    logic       put_key;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_delete;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic lc_out;
    logic pick_less;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/mhpq_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mhpq_datapath.sv -----
// Heap datapath: key store, fill count, sift position and key compares.
`default_nettype none

module mhpq_datapath #(
  parameter int CAPACITY = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mhpq_pkg::ctrl_cmd_t           cmd,
  input  wire logic                          command,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0] key,
  output mhpq_pkg::dp_status_t               status,
  output logic signed [mhpq_pkg::KEY_W-1:0]  min_key,
  output logic                               is_empty,
  output logic [mhpq_pkg::CNT_OUT_W-1:0]     entry_count,
  output logic                               op_error
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;
  localparam int OW = mhpq_pkg::CNT_OUT_W;
  localparam int KW = mhpq_pkg::KEY_W;

  logic [CW-1:0]        count;
  logic [IW-1:0]        pos;
  logic                 op_cmd;
  logic                 err;
  logic signed [KW-1:0] mov_key;
  logic signed [KW-1:0] left_val;

  logic signed [KW-1:0] rd_data;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  logic signed [KW-1:0] wr_data;

  logic [IW-1:0]        parent;
  logic [XW-1:0]        lc_w;
  logic [XW-1:0]        rc_w;
  logic [XW-1:0]        cnt_w;
  logic [CW-1:0]        last;
  logic                 take_right;
  logic signed [KW-1:0] pick_val;
  logic [IW-1:0]        pick_idx;

  // Tree neighbors of the current position
  assign parent = (pos - IW'(1)) >> 1;
  assign lc_w   = XW'({pos, 1'b1});
  assign rc_w   = lc_w + XW'(1);
  assign cnt_w  = XW'(count);
  assign last   = count - CW'(1);

  // Choose the smaller child, left on a tie
  assign take_right = (rc_w < cnt_w) && (rd_data < left_val);
  assign pick_val   = take_right ? rd_data : left_val;
  assign pick_idx   = take_right ? rc_w[IW-1:0] : lc_w[IW-1:0];

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      mhpq_pkg::RD_LAST:   rd_addr = last[IW-1:0];
      mhpq_pkg::RD_PARENT: rd_addr = parent;
      mhpq_pkg::RD_LEFT:   rd_addr = lc_w[IW-1:0];
      mhpq_pkg::RD_RIGHT:  rd_addr = rc_w[IW-1:0];
      mhpq_pkg::RD_ROOT:   rd_addr = '0;
      default:             rd_addr = '0;
    endcase
  end

  // Write the hole at the current position
  assign wr_en = cmd.up_step | cmd.dn_step | cmd.put_key;
  always_comb begin
    if (cmd.up_step) begin
      wr_data = rd_data;
    end else if (cmd.dn_step) begin
      wr_data = pick_val;
    end else begin
      wr_data = mov_key;
    end
  end

  mhpq_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Fill count and error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= 1'b0;
    end else begin
      if (cmd.count_inc) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= last;
      end
      if (cmd.load) begin
        err <= 1'b0;
      end else if (cmd.set_err) begin
        err <= 1'b1;
      end
    end
  end

  // Hold operation word, moving key, sift position and left child key
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_cmd  <= command;
      mov_key <= key;
    end else if (cmd.key_from_rd) begin
      mov_key <= rd_data;
    end
    if (cmd.count_inc) begin
      pos <= count[IW-1:0];
    end else if (cmd.key_from_rd) begin
      pos <= '0;
    end else if (cmd.up_step) begin
      pos <= parent;
    end else if (cmd.dn_step) begin
      pos <= pick_idx;
    end
    if (cmd.latch_left) begin
      left_val <= rd_data;
    end
  end

  // Status to controller
  always_comb begin
    status.op_delete = (op_cmd == mhpq_pkg::OP_DELETE);
    status.full      = (count == CW'(CAPACITY));
    status.empty     = (count == '0);
    status.pos_zero  = (pos == '0);
    status.up_less   = (mov_key < rd_data);
    status.lc_out    = (lc_w >= cnt_w);
    status.pick_less = (pick_val < mov_key);
  end

  // Result fields; root was read just before the result cycle
  assign min_key     = (count == '0) ? '0 : rd_data;
  assign is_empty    = (count == '0);
  assign entry_count = OW'(count);
  assign op_error    = err;

  // Count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // Sift-up moves toward the root
  a_up_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.up_step |=> pos < $past(pos))
    else $error("sift-up did not move toward root");

  // Sift-down moves toward the leaves
  a_dn_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.dn_step |=> pos > $past(pos))
    else $error("sift-down did not move toward leaves");

  // A rejected operation leaves the count alone
  a_err_count: assert property (@(posedge clk) disable iff (rst)
    cmd.set_err |=> count == $past(count))
    else $error("count changed on rejected operation");

endmodule

`default_nettype wire

// ----- rtl/mhpq_ctrl.sv -----
// Heap controller: sequences insert, delete and the root readback.
`default_nettype none

module mhpq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire mhpq_pkg::dp_status_t status,
  output mhpq_pkg::ctrl_cmd_t       cmd,
  output logic                      busy,
  output logic                      done
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_UP_TEST = 4'd2;
  localparam logic [3:0] S_UP_CMP  = 4'd3;
  localparam logic [3:0] S_DN_LOAD = 4'd4;
  localparam logic [3:0] S_DN_TEST = 4'd5;
  localparam logic [3:0] S_DN_LEFT = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_ROOT    = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.op_delete) begin
          if (status.full) begin
            cmd.set_err = 1'b1;
            state_next  = S_ROOT;
          end else begin
            cmd.count_inc = 1'b1;
            state_next    = S_UP_TEST;
          end
        end else begin
          if (status.empty) begin
            cmd.set_err = 1'b1;
            state_next  = S_ROOT;
          end else begin
            cmd.count_dec = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = mhpq_pkg::RD_LAST;
            state_next    = S_DN_LOAD;
          end
        end
      end
      S_UP_TEST: begin
        if (status.pos_zero) begin
          cmd.put_key = 1'b1;
          state_next  = S_ROOT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = mhpq_pkg::RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status.up_less) begin
          cmd.up_step = 1'b1;
          state_next  = S_UP_TEST;
        end else begin
          cmd.put_key = 1'b1;
          state_next  = S_ROOT;
        end
      end
      S_DN_LOAD: begin
        // take the last entry as the new root candidate
        cmd.key_from_rd = 1'b1;
        state_next      = status.empty ? S_ROOT : S_DN_TEST;
      end
      S_DN_TEST: begin
        if (status.lc_out) begin
          cmd.put_key = 1'b1;
          state_next  = S_ROOT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = mhpq_pkg::RD_LEFT;
          state_next = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        cmd.latch_left = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = mhpq_pkg::RD_RIGHT;
        state_next     = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (status.pick_less) begin
          cmd.dn_step = 1'b1;
          state_next  = S_DN_TEST;
        end else begin
          cmd.put_key = 1'b1;
          state_next  = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = mhpq_pkg::RD_ROOT;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // Result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // An accepted word starts the sequencer at once and no result comes next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy && !done)
    else $error("accepted word did not start the sequencer");

  // A delete never runs down on a word that also bumps the count
  a_one_count_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.count_inc && cmd.count_dec))
    else $error("count raised and lowered together");

endmodule

`default_nettype wire

// ----- rtl/min_heap_priority_queue_core.sv -----
// Top level of the min-heap priority queue core.
//
//   channel   handshake              payload
//   input     start / busy           command, key
//   result    done (one-cycle pulse) min_key, is_empty, entry_count, op_error
//
// A word is taken when start is high and busy is low; busy stays high until
// the result pulse has gone, so the next word is taken the cycle after it.
// An insert climbs at most log2(CAPACITY) levels and a delete descends at most
// as many; a delete that empties the heap does not sift, and a rejected word
// goes straight to the root readback. The single read port of the key store,
// with its registered read, paces each step. Results cannot be stalled.
// Synchronous reset empties the heap; the store itself is not cleared, since
// only entries below the fill count are ever used.
`default_nettype none

module min_heap_priority_queue_core #(
  parameter int CAPACITY = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              command,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0] key,
  output logic                                   done,
  output logic signed [mhpq_pkg::KEY_W-1:0]      min_key,
  output logic                                   is_empty,
  output logic [mhpq_pkg::CNT_OUT_W-1:0]         entry_count,
  output logic                                   op_error
);

  mhpq_pkg::ctrl_cmd_t  cmd;
  mhpq_pkg::dp_status_t status;

  mhpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mhpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .command     (command),
    .key         (key),
    .status      (status),
    .min_key     (min_key),
    .is_empty    (is_empty),
    .entry_count (entry_count),
    .op_error    (op_error)
  );

endmodule

`default_nettype wire
